>>> design/fbca_pkg.sv
package fbca_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

    // field widths
    localparam int CMD_W  = 3;
    localparam int BLK_W  = 16;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;

    // fixed values
    localparam logic [BLK_W-1:0] END_MARK    = 16'hFFFF;
    localparam logic [BLK_W-1:0] SYS_BLOCKS  = 16'd5;
    localparam logic [CNT_W-1:0] FREE_MAX    = 13'h1FFF;
    localparam logic [CNT_W-1:0] TOTAL_RESET = 13'd2048;
    localparam logic [CNT_W-1:0] FREE_RESET  = 13'd2043;

    // request opcodes
    typedef enum logic [CMD_W-1:0] {
        OP_FORMAT = 3'd0,
        OP_LOAD   = 3'd1,
        OP_HEADER = 3'd2,
        OP_ALLOC  = 3'd3,
        OP_FREE   = 3'd4,
        OP_LOOKUP = 3'd5
    } fbca_op_t;

    // response status codes
    typedef enum logic [STAT_W-1:0] {
        RS_OK       = 2'd0,
        RS_BAD_REQ  = 2'd1,
        RS_NO_SPACE = 2'd2,
        RS_CORRUPT  = 2'd3
    } fbca_status_t;

    // source of the response block field
    typedef enum logic [1:0] {
        RES_END,
        RES_DATA,
        RES_HEAD
    } fbca_res_sel_t;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FMT_CLEAR,
        ST_LOOKUP_DATA,
        ST_FREE_CHECK,
        ST_FREE_STEP,
        ST_ALLOC_CHECK,
        ST_ALLOC_READ,
        ST_ALLOC_TEST,
        ST_ALLOC_MARK,
        ST_DONE
    } fbca_state_t;

    // request word
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BLK_W-1:0] block_num;
        logic [BLK_W-1:0] entry_value;
        logic [CNT_W-1:0] block_count;
    } fbca_req_t;

    // response word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  result_block;
        logic [CNT_W-1:0]  free_now;
        logic [BLK_W-1:0]  last_now;
    } fbca_rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic          item_load;
        logic          clr_write;
        logic          fmt_header;
        logic          hdr_load;
        logic          entry_write;
        logic          free_step;
        logic          alloc_init;
        logic          alloc_adv;
        logic          alloc_link;
        logic          alloc_mark;
        logic          alloc_commit;
        logic          res_load;
        fbca_status_t  res_status;
        fbca_res_sel_t res_sel;
        logic          out_load;
    } fbca_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             cur_end;
        logic             rd_zero;
        logic             left_zero;
        logic             count_hit;
        logic             want_zero;
        logic             want_big;
        logic             clr_last;
        logic             out_free;
    } fbca_sts_t;

endpackage

>>> design/fbca_ram.sv
module fbca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/fbca_dp.sv
module fbca_dp
    import fbca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fbca_req_t        req,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  logic             rsp_ready,
    input  fbca_ctl_t        ctl,
    output fbca_sts_t        sts,
    output logic             rsp_valid,
    output fbca_rsp_t        rsp
);

    logic [CNT_W-1:0]  tb_reg;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [BLK_W-1:0]  last_reg, last_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              rsp_valid_reg;
    fbca_rsp_t         rsp_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [BLK_W-1:0]  ev_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [BLK_W-1:0]  cur_reg, cur_next;
    logic [ADDR_W-1:0] prev_reg;
    logic [BLK_W-1:0]  head_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  count_reg;
    fbca_status_t      status_reg;
    logic [BLK_W-1:0]  res_reg;

    logic [CNT_W-1:0]  nt;
    logic [CNT_W-1:0]  limit;
    logic [BLK_W-1:0]  cur_inc;
    logic [BLK_W-1:0]  cur_wrap;
    logic              in_range;
    logic              head_none;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BLK_W-1:0]  wdata;
    logic [BLK_W-1:0]  rdata;

    // card size clamped to the table, and the scan limit
    assign nt       = (32'(tb_reg) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES) : tb_reg;
    assign limit    = (nt > CNT_W'(SYS_BLOCKS)) ? (nt - CNT_W'(SYS_BLOCKS)) : '0;
    assign in_range = (cur_reg >= SYS_BLOCKS) && (32'(cur_reg) < 32'(nt));
    assign head_none = (head_reg == END_MARK);

    // next-fit candidate with wrap to the first data block
    assign cur_inc  = cur_reg + 16'd1;
    assign cur_wrap = ((cur_inc < SYS_BLOCKS) || (32'(cur_inc) >= 32'(nt))) ?
                      SYS_BLOCKS : cur_inc;

    // table write port select
    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg[ADDR_W-1:0];
        wdata = '0;
        if (ctl.clr_write)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
        end
        else if (ctl.entry_write)
        begin
            we    = 1'b1;
            wdata = ev_reg;
        end
        else if (ctl.free_step)
        begin
            we    = 1'b1;
        end
        else if (ctl.alloc_link && !head_none)
        begin
            we    = 1'b1;
            waddr = prev_reg;
            wdata = cur_reg;
        end
        else if (ctl.alloc_mark)
        begin
            we    = 1'b1;
            wdata = END_MARK;
        end
    end

    fbca_ram #(
        .WIDTH (BLK_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cur_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // header next values
    always_comb
    begin
        free_next = free_reg;
        last_next = last_reg;
        if (ctl.fmt_header)
        begin
            free_next = limit;
            last_next = SYS_BLOCKS;
        end
        else if (ctl.hdr_load)
        begin
            free_next = cnt_reg;
            last_next = cur_reg;
        end
        else if (ctl.alloc_commit)
        begin
            free_next = free_reg - cnt_reg;
            last_next = cur_reg;
        end
        else if (ctl.free_step && (free_reg < FREE_MAX))
        begin
            free_next = free_reg + 13'd1;
        end
    end

    // block pointer next value
    always_comb
    begin
        cur_next = cur_reg;
        if (ctl.item_load)
        begin
            cur_next = (req.cmd == OP_ALLOC) ? last_reg : req.block_num;
        end
        else if (ctl.alloc_adv)
        begin
            cur_next = cur_wrap;
        end
        else if (ctl.free_step)
        begin
            cur_next = rdata;
        end
    end

    // header, config, sweep counter and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tb_reg        <= TOTAL_RESET;
            free_reg      <= FREE_RESET;
            last_reg      <= SYS_BLOCKS;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tb_reg <= cfg_data;
            end
            free_reg <= free_next;
            last_reg <= last_next;
            if (ctl.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (ctl.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (ctl.item_load)
        begin
            cmd_reg <= req.cmd;
            ev_reg  <= req.entry_value;
            cnt_reg <= req.block_count;
        end
        if (ctl.alloc_init)
        begin
            head_reg  <= END_MARK;
            left_reg  <= cnt_reg;
            count_reg <= '0;
        end
        if (ctl.alloc_adv)
        begin
            count_reg <= count_reg + 13'd1;
        end
        if (ctl.alloc_link && head_none)
        begin
            head_reg <= cur_reg;
        end
        if (ctl.alloc_mark)
        begin
            prev_reg <= cur_reg[ADDR_W-1:0];
            left_reg <= left_reg - 13'd1;
        end
        if (ctl.res_load)
        begin
            status_reg <= ctl.res_status;
            case (ctl.res_sel)
                RES_DATA: res_reg <= rdata;
                RES_HEAD: res_reg <= head_reg;
                default:  res_reg <= END_MARK;
            endcase
        end
        if (ctl.out_load)
        begin
            rsp_reg.status       <= status_reg;
            rsp_reg.result_block <= res_reg;
            rsp_reg.free_now     <= free_reg;
            rsp_reg.last_now     <= last_reg;
        end
    end

    // status to the controller
    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.in_range  = in_range;
        sts.cur_end   = (cur_reg == END_MARK);
        sts.rd_zero   = (rdata == '0);
        sts.left_zero = (left_reg == '0);
        sts.count_hit = ((14'(count_reg) + 14'd1) >= 14'(limit));
        sts.want_zero = (cnt_reg == '0);
        sts.want_big  = (cnt_reg > free_reg);
        sts.clr_last  = (clr_addr_reg == '1);
        sts.out_free  = !rsp_valid_reg || rsp_ready;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // a block is only marked while blocks are still wanted
    a_mark_needs_left: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.alloc_mark |-> (left_reg != '0))
        else $error("chain mark with nothing left to allocate");

    // freeing only touches data blocks on the card
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.free_step |-> in_range)
        else $error("free step outside the card");

    // a response word never overwrites one still waiting
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwritten before it was taken");
`endif

endmodule

>>> design/fbca_ctrl.sv
module fbca_ctrl
    import fbca_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  fbca_sts_t sts,
    output fbca_ctl_t ctl
);

    fbca_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.cmd)
                    OP_FORMAT: state_next = ST_FMT_CLEAR;
                    OP_LOOKUP: state_next = sts.in_range ? ST_LOOKUP_DATA : ST_DONE;
                    OP_FREE:   state_next = ST_FREE_CHECK;
                    OP_ALLOC:
                    begin
                        if (sts.want_zero || sts.want_big)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ALLOC_CHECK;
                        end
                    end
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_FMT_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOOKUP_DATA:
            begin
                state_next = ST_DONE;
            end
            ST_FREE_CHECK:
            begin
                if (sts.cur_end || !sts.in_range)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_FREE_STEP;
                end
            end
            ST_FREE_STEP:
            begin
                state_next = ST_FREE_CHECK;
            end
            ST_ALLOC_CHECK:
            begin
                if (sts.left_zero || sts.count_hit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ALLOC_READ;
                end
            end
            ST_ALLOC_READ:
            begin
                state_next = ST_ALLOC_TEST;
            end
            ST_ALLOC_TEST:
            begin
                state_next = sts.rd_zero ? ST_ALLOC_MARK : ST_ALLOC_CHECK;
            end
            ST_ALLOC_MARK:
            begin
                state_next = ST_ALLOC_CHECK;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        ctl       = '0;
        ctl.res_status = RS_OK;
        ctl.res_sel    = RES_END;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR, ST_FMT_CLEAR:
            begin
                ctl.clr_write = 1'b1;
            end
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                ctl.item_load = req_valid;
            end
            ST_DECODE:
            begin
                unique case (sts.cmd)
                    OP_FORMAT:
                    begin
                        ctl.fmt_header = 1'b1;
                        ctl.res_load   = 1'b1;
                    end
                    OP_LOAD:
                    begin
                        ctl.entry_write = sts.in_range;
                        ctl.res_load    = 1'b1;
                        ctl.res_status  = sts.in_range ? RS_OK : RS_CORRUPT;
                    end
                    OP_HEADER:
                    begin
                        ctl.hdr_load = 1'b1;
                        ctl.res_load = 1'b1;
                    end
                    OP_ALLOC:
                    begin
                        if (sts.want_zero)
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = RS_BAD_REQ;
                        end
                        else if (sts.want_big)
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = RS_NO_SPACE;
                        end
                        else
                        begin
                            ctl.alloc_init = 1'b1;
                        end
                    end
                    OP_FREE:
                    begin
                    end
                    OP_LOOKUP:
                    begin
                        if (!sts.in_range)
                        begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = RS_CORRUPT;
                        end
                    end
                    default:
                    begin
                        ctl.res_load   = 1'b1;
                        ctl.res_status = RS_BAD_REQ;
                    end
                endcase
            end
            ST_LOOKUP_DATA:
            begin
                ctl.res_load = 1'b1;
                ctl.res_sel  = RES_DATA;
            end
            ST_FREE_CHECK:
            begin
                if (sts.cur_end)
                begin
                    ctl.res_load = 1'b1;
                end
                else if (!sts.in_range)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = RS_CORRUPT;
                end
            end
            ST_FREE_STEP:
            begin
                ctl.free_step = 1'b1;
            end
            ST_ALLOC_CHECK:
            begin
                if (sts.left_zero)
                begin
                    ctl.alloc_commit = 1'b1;
                    ctl.res_load     = 1'b1;
                    ctl.res_sel      = RES_HEAD;
                end
                else if (sts.count_hit)
                begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = RS_CORRUPT;
                end
                else
                begin
                    ctl.alloc_adv = 1'b1;
                end
            end
            ST_ALLOC_READ:
            begin
            end
            ST_ALLOC_TEST:
            begin
                ctl.alloc_link = sts.rd_zero;
            end
            ST_ALLOC_MARK:
            begin
                ctl.alloc_mark = 1'b1;
            end
            ST_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    // an accepted word is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted word not decoded");

    // the table is never written while waiting for a word
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(ctl.clr_write || ctl.entry_write ||
        ctl.free_step || ctl.alloc_link || ctl.alloc_mark))
        else $error("table write while idle");

    // handing a response over always returns to idle
    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> (state_reg == ST_IDLE))
        else $error("response loaded without returning to idle");
`endif

endmodule

>>> design/fat_block_chain_allocator_core.sv
// channel | direction | handshake               | word
// req     | in        | req_valid / req_ready   | cmd, block_num, entry_value, block_count
// rsp     | out       | rsp_valid / rsp_ready   | status, result_block, free_now, last_now
// cfg     | in        | cfg_valid / cfg_ready   | total_blocks
//
// after reset the table is swept to zero, one entry a cycle;
// req_ready stays low until the sweep ends, cfg writes are taken at any time
// format repeats the same sweep; free walks the chain and clears each link;
// allocate tests candidate blocks in turn and marks each free one it takes,
// using the single table write port and its registered read
// a new word is taken while the previous response still waits on rsp_ready
module fat_block_chain_allocator_core
    import fbca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  fbca_req_t        req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output fbca_rsp_t        rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    fbca_ctl_t ctl;
    fbca_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    fbca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    fbca_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_ready (rsp_ready),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
